// File: hdl/bae_pkg.sv
// Shared types and constants for the binary arithmetic encoder.
// Used by bae_front, bae_queue, bae_back and binary_arithmetic_encoder.
// Depends on nothing else.
package bae_pkg;

    // Operation codes carried by an input request.
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // Interval bounds after reset and after a flush.
    localparam logic [31:0] RESET_LOW  = 32'h0000_0000;
    localparam logic [31:0] RESET_HIGH = 32'hffff_ffff;

    // A request causes at most four bytes.
    localparam int MAX_BYTES = 4;
    localparam int CNT_W     = 3;

    // Default depth of the job queue between front and back.
    localparam int JOB_QUEUE_DEPTH = 2;

    // One unit of work for the back end: the bytes are taken from the top
    // of 'bytes', most significant first, 'count' of them.
    typedef struct packed {
        logic [31:0]      bytes;
        logic [CNT_W-1:0] count;
    } t_job;

endpackage

// File: hdl/bae_front.sv
// Front end of the encoder: accepts requests, splits the interval and
// normalises the bounds, queueing shared bytes and a flush's last byte.
// Depends on bae_pkg.
module bae_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_op,
    input  logic [15:0]         i_prob_one,
    input  logic                i_bit_value,
    output logic                o_push,
    output bae_pkg::t_job       o_job,
    input  logic                i_full
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SPLIT = 2'd1;
    localparam logic [1:0] ST_NORM  = 2'd2;

    // Number of leading bytes in which the two bounds agree (0 to 4).
    function automatic logic [bae_pkg::CNT_W-1:0] shared_bytes(input logic [31:0] x);
        logic [bae_pkg::CNT_W-1:0] n;
        if (x[31:24] != 8'h00) begin
            n = 3'd0;
        end else if (x[23:16] != 8'h00) begin
            n = 3'd1;
        end else if (x[15:8] != 8'h00) begin
            n = 3'd2;
        end else if (x[7:0] != 8'h00) begin
            n = 3'd3;
        end else begin
            n = 3'd4;
        end
        return n;
    endfunction

    logic [1:0]  r_state, n_state;
    logic [31:0] r_low, n_low;
    logic [31:0] r_high, n_high;
    logic [31:0] r_range, n_range;
    logic        r_op;
    logic        r_bit;
    logic [31:0] r_prod_hi;
    logic [31:0] r_prod_lo;

    logic        w_accept;
    logic [31:0] w_split;
    logic [31:0] w_split_up;
    logic [bae_pkg::CNT_W-1:0] w_shared;
    logic [bae_pkg::CNT_W-1:0] w_flush_n;
    logic [bae_pkg::CNT_W-1:0] w_count;
    logic [5:0]  w_shift;
    logic [31:0] w_low_sh;
    logic [31:0] w_high_sh;
    logic        w_can_go;

    assign o_stall  = (r_state != ST_IDLE);
    assign w_accept = i_valid && !o_stall;

    // Split point; a zero moves the low bound to one above it.
    assign w_split    = r_low + r_prod_hi + {16'h0000, r_prod_lo[31:16]};
    assign w_split_up = w_split + 32'd1;

    assign w_shared  = shared_bytes(r_low ^ r_high);
    assign w_flush_n = (w_shared == 3'd4) ? 3'd3 : w_shared;
    assign w_count   = (r_op == bae_pkg::OP_FLUSH) ? (w_flush_n + 3'd1) : w_shared;
    assign w_shift   = {w_shared, 3'b000};
    assign w_low_sh  = r_low << w_shift;
    assign w_high_sh = ~((~r_high) << w_shift);

    assign w_can_go = (w_count == '0) || !i_full;

    assign o_push      = (r_state == ST_NORM) && (w_count != '0) && !i_full;
    assign o_job.bytes = r_high;
    assign o_job.count = w_count;

    always_comb begin
        n_state = r_state;
        n_low   = r_low;
        n_high  = r_high;
        n_range = r_range;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SPLIT;
                end
            end
            ST_SPLIT: begin
                if (r_op == bae_pkg::OP_ENCODE) begin
                    if (r_bit) begin
                        n_high = w_split;
                    end else begin
                        n_low = w_split_up;
                    end
                end
                n_state = ST_NORM;
            end
            ST_NORM: begin
                if (w_can_go) begin
                    if (r_op == bae_pkg::OP_FLUSH) begin
                        n_low   = bae_pkg::RESET_LOW;
                        n_high  = bae_pkg::RESET_HIGH;
                        n_range = bae_pkg::RESET_HIGH - bae_pkg::RESET_LOW;
                    end else begin
                        n_low   = w_low_sh;
                        n_high  = w_high_sh;
                        n_range = w_high_sh - w_low_sh;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_low   <= bae_pkg::RESET_LOW;
            r_high  <= bae_pkg::RESET_HIGH;
            r_range <= bae_pkg::RESET_HIGH - bae_pkg::RESET_LOW;
        end else begin
            r_state <= n_state;
            r_low   <= n_low;
            r_high  <= n_high;
            r_range <= n_range;
        end
    end

    // Request payload and the two partial products of range times p.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= i_op;
            r_bit     <= i_bit_value;
            r_prod_hi <= {16'h0000, r_range[31:16]} * {16'h0000, i_prob_one};
            r_prod_lo <= {16'h0000, r_range[15:0]} * {16'h0000, i_prob_one};
        end
    end

endmodule

// File: hdl/bae_queue.sv
// Small first-in first-out queue of byte jobs between front and back.
// Depends on bae_pkg.
module bae_queue #(
    parameter int DEPTH = bae_pkg::JOB_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bae_pkg::t_job i_push_job,
    output logic          o_full,
    input  logic          i_pop,
    output bae_pkg::t_job o_pop_job,
    output logic          o_empty
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    bae_pkg::t_job   r_mem [DEPTH];
    logic [IDX_W-1:0]  r_wr, n_wr;
    logic [IDX_W-1:0]  r_rd, n_rd;
    logic [FILL_W-1:0] r_fill, n_fill;

    assign o_full    = (r_fill == FILL_W'(DEPTH));
    assign o_empty   = (r_fill == '0);
    assign o_pop_job = r_mem[r_rd];

    always_comb begin
        n_wr   = r_wr;
        n_rd   = r_rd;
        n_fill = r_fill;
        if (i_push) begin
            n_wr = (r_wr == IDX_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == IDX_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (i_pop && !i_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

endmodule

// File: hdl/bae_back.sv
// Back end of the encoder: takes byte jobs from the queue and sends
// the bytes out one per unstalled cycle, marking each job's last byte.
// Depends on bae_pkg.
module bae_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  bae_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [7:0]    o_out_byte,
    output logic          o_last_of_run
);

    logic                      r_valid, n_valid;
    logic [31:0]               r_bytes, n_bytes;
    logic [bae_pkg::CNT_W-1:0] r_left, n_left;
    logic                      w_last;
    logic                      w_free;

    assign w_last = (r_left == 3'd1);
    // The output register is free, or frees up at this edge.
    assign w_free = !r_valid || (!i_stall && w_last);
    assign o_pop  = i_job_valid && w_free;

    assign o_valid       = r_valid;
    assign o_out_byte    = r_bytes[31:24];
    assign o_last_of_run = w_last;

    always_comb begin
        n_valid = r_valid;
        n_bytes = r_bytes;
        n_left  = r_left;
        if (o_pop) begin
            n_valid = 1'b1;
            n_bytes = i_job.bytes;
            n_left  = i_job.count;
        end else if (w_free) begin
            n_valid = 1'b0;
        end else if (!i_stall) begin
            n_bytes = {r_bytes[23:0], 8'h00};
            n_left  = r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
        end else begin
            r_valid <= n_valid;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
    end

endmodule

// File: hdl/binary_arithmetic_encoder.sv
// Binary arithmetic encoder with 32-bit interval bounds, top level.
// Instantiates bae_front, bae_queue and bae_back; depends on bae_pkg.
//
// Use: an input request carries i_op, i_prob_one and i_bit_value and is
// taken at a rising edge where i_valid is high and o_stall is low. An encode
// request narrows the interval and yields zero to four bytes; a flush request
// yields the final byte and restarts the coder. Each output request carries
// o_out_byte and o_last_of_run and is taken where o_valid is high and i_stall
// is low; o_last_of_run marks the final byte caused by one input request.
//
// Flow: the front end takes each input request through multiply, split,
// then normalise and enqueue, holding o_stall high until it is back in
// idle, so it accepts no new request before it is through with the last;
// normalise waits while the job queue is full. The job is queued at the
// end of the normalise cycle and loaded into the output register once
// the back end is free. The back end sends one byte a cycle while the
// receiver does not stall, and the job queue lets the front end carry on.
//
// Reset (synchronous, active low) sets the bounds to the full interval and
// empties the queue and output register. While the receiver stalls, the byte
// on offer holds; the queue fills and then the front end holds o_stall high.
module binary_arithmetic_encoder #(
    parameter int QUEUE_DEPTH = bae_pkg::JOB_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [15:0] i_prob_one,
    input  logic        i_bit_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run
);

    logic          w_push;
    bae_pkg::t_job w_push_job;
    logic          w_full;
    logic          w_pop;
    bae_pkg::t_job w_pop_job;
    logic          w_empty;

    // Front: request acceptance, interval split and normalisation.
    bae_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_prob_one  (i_prob_one),
        .i_bit_value (i_bit_value),
        .o_push      (w_push),
        .o_job       (w_push_job),
        .i_full      (w_full)
    );

    // Jobs waiting for the back end.
    bae_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_job (w_push_job),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_pop_job  (w_pop_job),
        .o_empty    (w_empty)
    );

    // Back: one byte per output request.
    bae_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (!w_empty),
        .i_job         (w_pop_job),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for binary_arithmetic_encoder: random and directed requests,
// with an interval-coder predictor held in a small class. Depends on bae_pkg and the RTL.
module tb;

    // The whole run must end well inside this many clock cycles. The slowest
    // correct run has every request yielding four bytes, each waiting out
    // long receiver stalls.
    localparam int CYCLE_LIMIT = 200000;
    // Cycles allowed after the last awaited byte, for anything stray to show.
    localparam int SETTLE_CYCLES = 24;
    // Length of the deliberate receiver hold-off that fills the block up.
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int RANDOM_PER_PHASE = 27;

    localparam logic [31:0] TOP_BYTE_MASK = 32'hff00_0000;
    localparam logic [31:0] LOW_HALF_MASK = 32'h0000_ffff;

    // One byte of the compressed stream as the receiver should see it.
    typedef struct packed {
        logic [7:0] value;
        logic       is_last;
    } t_coded_byte;

    // Tracks the coder's interval exactly as the block should, and keeps the
    // bytes that the accepted requests are bound to produce, oldest first.
    class coded_stream;
        logic [31:0] low_bound;
        logic [31:0] high_bound;
        t_coded_byte awaited_bytes[$];
        int          mismatches;

        function new();
            restart_interval();
            mismatches = 0;
        endfunction

        function void restart_interval();
            low_bound  = bae_pkg::RESET_LOW;
            high_bound = bae_pkg::RESET_HIGH;
        endfunction

        // Appends one byte to the tail of the awaited stream.
        function void await_byte(logic [7:0] value, logic is_last);
            t_coded_byte item;
            item.value    = value;
            item.is_last  = is_last;
            awaited_bytes = {awaited_bytes, item};
        endfunction

        // Shifts out shared top bytes, at most 'limit' of them.
        function int shift_out_shared(int limit);
            int n;
            n = 0;
            while (n < limit && ((low_bound ^ high_bound) & TOP_BYTE_MASK) == 32'h0) begin
                await_byte(high_bound[31:24], 1'b0);
                low_bound  = low_bound << 8;
                high_bound = (high_bound << 8) | 32'h0000_00ff;
                n++;
            end
            return n;
        endfunction

        function void note_request(logic op, logic [15:0] prob, logic bit_in);
            logic [31:0] span;
            logic [31:0] split;
            logic [31:0] prob_wide;
            int          n;
            if (op == bae_pkg::OP_ENCODE) begin
                span      = high_bound - low_bound;
                prob_wide = {16'h0000, prob};
                split     = low_bound + (span >> 16) * prob_wide
                            + (((span & LOW_HALF_MASK) * prob_wide) >> 16);
                if (bit_in)
                    high_bound = split;
                else
                    low_bound = split + 32'd1;
                n = shift_out_shared(bae_pkg::MAX_BYTES);
                if (n > 0)
                    awaited_bytes[awaited_bytes.size() - 1].is_last = 1'b1;
            end else begin
                // A flush never finds a shared top byte in practice, but the
                // coder still tries up to three before its final byte.
                n = shift_out_shared(bae_pkg::MAX_BYTES - 1);
                await_byte(high_bound[31:24], 1'b1);
                restart_interval();
            end
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("%0t tb: mismatch: %s", $time, what);
        endtask

        task check_byte(logic [7:0] got_value, logic got_last);
            t_coded_byte want;
            if (awaited_bytes.size() == 0) begin
                report_mismatch($sformatf("byte %02h (last %0b) with nothing awaited",
                                          got_value, got_last));
                return;
            end
            want = awaited_bytes.pop_front();
            if (got_value !== want.value)
                report_mismatch($sformatf("out_byte %02h, wanted %02h", got_value, want.value));
            if (got_last !== want.is_last)
                report_mismatch($sformatf("last_of_run %0b, wanted %0b on byte %02h",
                                          got_last, want.is_last, want.value));
        endtask

        function int bytes_awaited();
            return awaited_bytes.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_op;
    logic [15:0] i_prob_one;
    logic        i_bit_value;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_out_byte;
    logic        o_last_of_run;

    coded_stream stream = new();

    // Idling rates, in percent, for the sender and the receiver.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // Bumped by the stimulus to ask the receiver for one long hold-off.
    int hold_asks     = 0;
    int cycle_count   = 0;

    binary_arithmetic_encoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_prob_one    (i_prob_one),
        .i_bit_value   (i_bit_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a run that has not finished by the limit has hung somewhere.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: FAIL");
        $finish;
    end

    // Offers one request, possibly after some idle cycles, and returns at the
    // edge where the block takes it. Valid is never lowered and raised in the
    // same step: the idle loop only runs before the request is put up.
    task automatic send_request(input logic op, input logic [15:0] prob, input logic bit_in);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_op        <= op;
        i_prob_one  <= prob;
        i_bit_value <= bit_in;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        stream.note_request(op, prob, bit_in);
    endtask

    // Holds the sender back until every awaited byte has arrived, then waits
    // out SETTLE_CYCLES in case the block still has something in hand.
    task automatic wait_drained();
        while (stream.bytes_awaited() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random requests. Most are encodes with probabilities spread over the
    // whole range and bunched at both ends, where intervals shrink fastest
    // and the four-byte case turns up; about one in ten is a flush. Half the
    // bits follow their probability, as real data would, so that long runs
    // of narrow intervals happen too.
    task automatic run_random(input int count);
        logic [15:0] prob;
        logic        bit_in;
        int          pick;
        repeat (count) begin
            pick = $urandom_range(19);
            if (pick == 0)
                prob = 16'h0000;
            else if (pick <= 3)
                prob = 16'($urandom_range(255, 1));
            else if (pick <= 6)
                prob = 16'($urandom_range(65535, 65280));
            else
                prob = 16'($urandom_range(65535, 1));
            if ($urandom_range(1) == 0)
                bit_in = 1'($urandom_range(1));
            else
                bit_in = ($urandom_range(65535) < prob);
            if ($urandom_range(9) == 0)
                send_request(bae_pkg::OP_FLUSH, prob, bit_in);
            else
                send_request(bae_pkg::OP_ENCODE, prob, bit_in);
        end
        i_valid <= 1'b0;
    endtask

    // Receiver: takes a byte wherever o_valid is high and i_stall is low, then
    // picks the stall for the next cycle. A long hold-off, once asked for, is
    // counted down here and overrides the random stalls.
    initial begin : byte_sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall)
                stream.check_byte(o_out_byte, o_last_of_run);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct) begin
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_op        <= bae_pkg::OP_ENCODE;
        i_prob_one  <= 16'h0000;
        i_bit_value <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, with neither side idling. A flush straight after
        // reset gives the top byte of the full interval.
        send_request(bae_pkg::OP_FLUSH, 16'h0000, 1'b0);
        // An even split that leaves the bounds with different top bytes, so
        // no byte comes out.
        send_request(bae_pkg::OP_ENCODE, 16'h8000, 1'b1);
        // Probability zero: a one collapses the interval and yields four
        // bytes, a zero merely lifts the low bound by one.
        send_request(bae_pkg::OP_ENCODE, 16'h0000, 1'b1);
        send_request(bae_pkg::OP_ENCODE, 16'h0000, 1'b0);
        send_request(bae_pkg::OP_ENCODE, 16'h0000, 1'b0);
        // Both ends of the probability range with both bit values.
        send_request(bae_pkg::OP_ENCODE, 16'hffff, 1'b1);
        send_request(bae_pkg::OP_ENCODE, 16'hffff, 1'b0);
        send_request(bae_pkg::OP_ENCODE, 16'h0001, 1'b0);
        send_request(bae_pkg::OP_ENCODE, 16'h0001, 1'b1);
        send_request(bae_pkg::OP_ENCODE, 16'h0001, 1'b1);
        send_request(bae_pkg::OP_ENCODE, 16'h0001, 1'b1);
        // A flush with its ignored fields all ones, then a second flush.
        send_request(bae_pkg::OP_FLUSH, 16'hffff, 1'b1);
        send_request(bae_pkg::OP_FLUSH, 16'h5a5a, 1'b0);
        // Unlikely zeros keep pushing the low bound up towards the high one.
        send_request(bae_pkg::OP_ENCODE, 16'hfffe, 1'b0);
        send_request(bae_pkg::OP_ENCODE, 16'hfffe, 1'b0);
        send_request(bae_pkg::OP_ENCODE, 16'hfffe, 1'b0);
        send_request(bae_pkg::OP_ENCODE, 16'h00ff, 1'b0);
        send_request(bae_pkg::OP_ENCODE, 16'hff00, 1'b1);
        send_request(bae_pkg::OP_ENCODE, 16'h0000, 1'b1);
        send_request(bae_pkg::OP_FLUSH, 16'h0000, 1'b1);
        i_valid <= 1'b0;
        wait_drained();

        // Random part in three phases: a fast sender with a slow receiver,
        // the other way round, and then both at full speed. Between phases
        // the sender waits for every awaited byte.
        send_idle_pct = 37;
        recv_idle_pct = 72;
        run_random(RANDOM_PER_PHASE);
        wait_drained();

        send_idle_pct = 72;
        recv_idle_pct = 37;
        run_random(RANDOM_PER_PHASE);
        wait_drained();

        // Full speed, opening with a long receiver hold-off so that the job
        // queue fills and the block stalls its input while requests wait.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asks <= hold_asks + 1;
        run_random(RANDOM_PER_PHASE);
        wait_drained();

        if (stream.bytes_awaited() != 0)
            stream.report_mismatch($sformatf("%0d bytes never arrived", stream.bytes_awaited()));
        if (stream.mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// File: binary_arithmetic_encoder.f
hdl/bae_pkg.sv
hdl/bae_front.sv
hdl/bae_queue.sv
hdl/bae_back.sv
hdl/binary_arithmetic_encoder.sv
bench/tb.sv
